/* rtl/ttyrf_pkg.sv */
`default_nettype none

package ttyrf_pkg;

  // bus event carried by one input word
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  // port numbers
  localparam logic [1:0] PORT_DATA   = 2'd0;  // id word on read, tx char on write
  localparam logic [1:0] PORT_RX     = 2'd1;  // rx char on read, mode on write
  localparam logic [1:0] PORT_STATUS = 2'd2;  // ready flag on read

  // configuration register indexes
  localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DEVICE_ID   = 2'd1;

  localparam int unsigned RateW = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;

  localparam logic [RateW-1:0] TickPeriodReset = 10'd50;
  localparam logic [ByteW-1:0] DeviceIdReset   = 8'd0;

  // bytes id, 't', 't', 'y' little-endian
  localparam logic [WordW-1:0] IdWordBase = 32'h7974_7400;

endpackage

`default_nettype wire

/* rtl/ttyrf_ram.sv */
`default_nettype none

module ttyrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tty_receive_fifo_device.sv */
`default_nettype none

// Terminal receive device with three ports. Every input word is one bus event
// (tick, port read or port write) and also carries the host input byte that is
// waiting now. Port 0 reads the id word and writes a character out, port 1
// reads a received character (sign-extended) and writes the mode (zero is
// polling, nonzero is interrupt and restarts the tick counter), port 2 reads
// the ready status. In interrupt mode a tick that finds the counter equal to
// the tick period register samples the host byte, if one is waiting, into a
// FIFO_DEPTH ring (dropping the oldest entry when it fills) and pulses irq.
// One word is accepted every cycle unless the result stalls, and each word
// gives exactly one result word: a word accepted at a clock edge is held in
// the input register, and its result then comes from the result register.
// A result that waits on m_axis_tready holds the input register, so the input
// side stalls with it; input and result move in the same cycle when the
// receiver is ready. The ring sits in a RAM whose read port is always
// addressed with the next head pointer, so the head byte is ready for the
// following word; a write that lands on that address is forwarded. Ring
// entries are only read after they are written, so no clearing pass is needed
// after reset.
module tty_receive_fifo_device #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_wdata_i,

  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // wdata[31:0], rx_valid[32], rx_byte[40:33], zero[47:41]
  input  wire logic [47:0] s_axis_tdata,
  // cmd[1:0], port[3:2]
  input  wire logic [3:0]  s_axis_tuser,

  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // rdata[31:0], tx_valid[32], tx_byte[40:33], rx_taken[41], irq[42], zero[47:43]
  output logic [47:0]      m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(FIFO_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FIFO_DEPTH - 1);

  // index advance with wrap at the ring depth
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] nxt;
    nxt = (idx == LastIdx) ? '0 : idx + IdxW'(1);
    return nxt;
  endfunction

  // configuration registers
  logic [ttyrf_pkg::RateW-1:0] tick_period_q;
  logic [ttyrf_pkg::ByteW-1:0] device_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= ttyrf_pkg::TickPeriodReset;
      device_id_q   <= ttyrf_pkg::DeviceIdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttyrf_pkg::CFG_TICK_PERIOD: tick_period_q <= cfg_wdata_i;
        ttyrf_pkg::CFG_DEVICE_ID:   device_id_q   <= cfg_wdata_i[ttyrf_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                        in_valid_q;
  ttyrf_pkg::cmd_e             in_cmd_q;
  logic [1:0]                  in_port_q;
  logic [ttyrf_pkg::WordW-1:0] in_wdata_q;
  logic                        in_rx_valid_q;
  logic [ttyrf_pkg::ByteW-1:0] in_rx_byte_q;

  // result register
  logic                        out_valid_q;
  logic [ttyrf_pkg::WordW-1:0] out_rdata_q, out_rdata_d;
  logic                        out_tx_valid_q, out_tx_valid_d;
  logic [ttyrf_pkg::ByteW-1:0] out_tx_byte_q, out_tx_byte_d;
  logic                        out_rx_taken_q, out_rx_taken_d;
  logic                        out_irq_q, out_irq_d;

  // device state
  logic                        int_mode_q, int_mode_d;
  logic [ttyrf_pkg::RateW-1:0] tick_cnt_q, tick_cnt_d;
  logic [IdxW-1:0]             wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]             rd_idx_q, rd_idx_d;

  // head forwarding around the ram read latency
  logic                        fwd_hit_q, fwd_hit_d;
  logic [ttyrf_pkg::ByteW-1:0] fwd_byte_q;
  logic [ttyrf_pkg::ByteW-1:0] ram_rdata;
  logic [ttyrf_pkg::ByteW-1:0] head_byte;

  logic                        ring_we;
  logic                        ring_ready;
  logic [IdxW-1:0]             wr_next;
  logic                        advance;

  // the word in the input register moves on when the result slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign ring_ready = (wr_idx_q != rd_idx_q);
  assign head_byte  = fwd_hit_q ? fwd_byte_q : ram_rdata;
  assign wr_next    = wrap_inc(wr_idx_q);

  always_comb begin
    out_rdata_d    = '0;
    out_tx_valid_d = 1'b0;
    out_tx_byte_d  = '0;
    out_rx_taken_d = 1'b0;
    out_irq_d      = 1'b0;
    int_mode_d     = int_mode_q;
    tick_cnt_d     = tick_cnt_q;
    wr_idx_d       = wr_idx_q;
    rd_idx_d       = rd_idx_q;
    ring_we        = 1'b0;

    if (advance) begin
      unique case (in_cmd_q)
        ttyrf_pkg::CMD_TICK: begin
          if (int_mode_q) begin
            if (tick_cnt_q == tick_period_q) begin
              tick_cnt_d = '0;
              if (in_rx_valid_q) begin
                ring_we        = 1'b1;
                wr_idx_d       = wr_next;
                out_rx_taken_d = 1'b1;
                out_irq_d      = 1'b1;
                // ring full: drop the oldest byte
                if (wrap_inc(wr_next) == rd_idx_q) begin
                  rd_idx_d = wrap_inc(rd_idx_q);
                end
              end
            end else begin
              tick_cnt_d = tick_cnt_q + 1'b1;
            end
          end
        end
        ttyrf_pkg::CMD_READ: begin
          unique case (in_port_q)
            ttyrf_pkg::PORT_DATA: begin
              out_rdata_d = ttyrf_pkg::IdWordBase | {24'd0, device_id_q};
            end
            ttyrf_pkg::PORT_RX: begin
              if (!int_mode_q) begin
                if (in_rx_valid_q) begin
                  out_rdata_d    = {{24{in_rx_byte_q[7]}}, in_rx_byte_q};
                  out_rx_taken_d = 1'b1;
                end
              end else if (ring_ready) begin
                out_rdata_d = {{24{head_byte[7]}}, head_byte};
                rd_idx_d    = wrap_inc(rd_idx_q);
              end
            end
            ttyrf_pkg::PORT_STATUS: begin
              out_rdata_d = {31'd0, int_mode_q ? ring_ready : in_rx_valid_q};
            end
            default: ;
          endcase
        end
        ttyrf_pkg::CMD_WRITE: begin
          if (in_port_q == ttyrf_pkg::PORT_DATA) begin
            out_tx_valid_d = 1'b1;
            out_tx_byte_d  = in_wdata_q[ttyrf_pkg::ByteW-1:0];
          end else if (in_port_q == ttyrf_pkg::PORT_RX) begin
            if (in_wdata_q == '0) begin
              int_mode_d = 1'b0;
            end else begin
              int_mode_d = 1'b1;
              tick_cnt_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    // ram reads the next head this cycle; a write to it must be forwarded
    fwd_hit_d = ring_we && (wr_idx_q == rd_idx_d);
  end

  ttyrf_ram #(
    .Width (ttyrf_pkg::ByteW),
    .Depth (FIFO_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wr_idx_q),
    .wdata_i (in_rx_byte_q),
    .raddr_i (rd_idx_d),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      int_mode_q  <= 1'b0;
      tick_cnt_q  <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      int_mode_q <= int_mode_d;
      tick_cnt_q <= tick_cnt_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q      <= ttyrf_pkg::cmd_e'(s_axis_tuser[1:0]);
      in_port_q     <= s_axis_tuser[3:2];
      in_wdata_q    <= s_axis_tdata[31:0];
      in_rx_valid_q <= s_axis_tdata[32];
      in_rx_byte_q  <= s_axis_tdata[40:33];
    end
    if (advance) begin
      out_rdata_q    <= out_rdata_d;
      out_tx_valid_q <= out_tx_valid_d;
      out_tx_byte_q  <= out_tx_byte_d;
      out_rx_taken_q <= out_rx_taken_d;
      out_irq_q      <= out_irq_d;
    end
    if (ring_we) begin
      fwd_byte_q <= in_rx_byte_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_irq_q, out_rx_taken_q, out_tx_byte_q,
                          out_tx_valid_q, out_rdata_q};

endmodule

`default_nettype wire

/* tb/sv/tty_receive_fifo_device_tb.sv */
`timescale 1ns / 1ps

module tty_receive_fifo_device_tb;
  import ttyrf_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int RingDepth   = 16;
  localparam int IdleLimit   = 2000;  // cycles with no word moving on either side
  localparam int SettleCycles = 4;    // result path is two registers deep
  localparam int DrainCycles  = 8;

  // codes the package leaves unnamed
  localparam logic [1:0] CmdSpare  = 2'd3;
  localparam logic [1:0] PortSpare = 2'd3;
  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;

  typedef logic [$clog2(RingDepth)-1:0] ptr_t;

  // one bus event plus the host byte waiting with it
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  port;
    logic [31:0] wdata;
    logic        rx_valid;
    logic [7:0]  rx_byte;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic        irq;
  } tty_result_t;

  typedef struct packed {
    bus_word_t   w;
    logic        typed;  // res holds the known answer
    tty_result_t res;
  } probe_row_t;

  localparam tty_result_t NoResult = '0;

  // directed words, run with the reset configuration, starting in polling mode
  localparam int NumProbes = 24;
  localparam probe_row_t ProbeRows [NumProbes] = '{
    // id word with reset id byte
    '{'{CMD_READ, PORT_DATA, 32'h0, 1'b0, 8'h00}, 1'b1, '{IdWordBase, 1'b0, 8'h00, 1'b0, 1'b0}},
    // polling reads take the host byte, sign-extended
    '{'{CMD_READ, PORT_RX, 32'h0, 1'b1, 8'h80}, 1'b1, '{32'hFFFF_FF80, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{'{CMD_READ, PORT_RX, 32'h0, 1'b1, 8'h7F}, 1'b1, '{32'h0000_007F, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{'{CMD_READ, PORT_RX, 32'hFFFF_FFFF, 1'b0, 8'hFF}, 1'b1, NoResult},
    '{'{CMD_READ, PORT_STATUS, 32'h0, 1'b1, 8'h00}, 1'b1, '{32'h1, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{CMD_READ, PORT_STATUS, 32'h0, 1'b0, 8'hFF}, 1'b1, NoResult},
    // unused port reads as zero
    '{'{CMD_READ, PortSpare, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1, NoResult},
    // character out, low byte only
    '{'{CMD_WRITE, PORT_DATA, 32'hFFFF_FFFF, 1'b0, 8'h00}, 1'b1, '{32'h0, 1'b1, 8'hFF, 1'b0, 1'b0}},
    '{'{CMD_WRITE, PORT_DATA, 32'h0000_0000, 1'b1, 8'hFF}, 1'b1, '{32'h0, 1'b1, 8'h00, 1'b0, 1'b0}},
    // writes to status and unused port are dropped
    '{'{CMD_WRITE, PORT_STATUS, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1, NoResult},
    '{'{CMD_WRITE, PortSpare, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1, NoResult},
    // unused command
    '{'{CmdSpare, PortSpare, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1, NoResult},
    // tick in polling mode does nothing
    '{'{CMD_TICK, PORT_DATA, 32'h0, 1'b1, 8'h11}, 1'b1, NoResult},
    // mode zero keeps polling, then switch to interrupt mode
    '{'{CMD_WRITE, PORT_RX, 32'h0, 1'b1, 8'h22}, 1'b1, NoResult},
    '{'{CMD_WRITE, PORT_RX, 32'h8000_0000, 1'b0, 8'h00}, 1'b1, NoResult},
    // interrupt mode, empty ring: read gives zero and never takes the host byte
    '{'{CMD_READ, PORT_RX, 32'h0, 1'b1, 8'h55}, 1'b1, NoResult},
    '{'{CMD_READ, PORT_STATUS, 32'h0, 1'b1, 8'h55}, 1'b1, NoResult},
    '{'{CMD_TICK, PORT_RX, 32'h0, 1'b1, 8'hAA}, 1'b0, NoResult},
    '{'{CMD_TICK, PORT_STATUS, 32'h0, 1'b1, 8'hAB}, 1'b0, NoResult},
    // nonzero mode write while already in interrupt mode restarts the count
    '{'{CMD_WRITE, PORT_RX, 32'h0000_0001, 1'b0, 8'h00}, 1'b0, NoResult},
    '{'{CMD_TICK, PORT_DATA, 32'h0, 1'b0, 8'h00}, 1'b0, NoResult},
    '{'{CMD_WRITE, PORT_RX, 32'hFFFF_FFFF, 1'b1, 8'h33}, 1'b0, NoResult},
    // back to polling
    '{'{CMD_WRITE, PORT_RX, 32'h0, 1'b0, 8'h00}, 1'b0, NoResult},
    '{'{CMD_READ, PORT_RX, 32'h0, 1'b1, 8'h00}, 1'b1, '{32'h0, 1'b0, 8'h00, 1'b1, 1'b0}}
  };

  // clock, reset, and every input known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [9:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [3:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  tty_receive_fifo_device #(
    .FIFO_DEPTH(RingDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),  // wdata[31:0], rx_valid[32], rx_byte[40:33], zero[47:41]
    .s_axis_tuser (s_axis_tuser),  // cmd[1:0], port[3:2]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)   // rdata[31:0], tx_valid[32], tx_byte[40:33],
                                   // rx_taken[41], irq[42], zero[47:43]
  );

  // device state as the predictor sees it
  logic [9:0]  rate_q;
  logic [7:0]  id_q;
  logic        irq_mode;
  logic [9:0]  tick_cnt;
  ptr_t        wr_ptr;
  ptr_t        rd_ptr;
  logic [7:0]  ring [RingDepth];

  tty_result_t owed_results [$];  // results still to come back, oldest first
  int n_errors  = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_samples = 0;
  int n_drops   = 0;
  int n_tx      = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [15:0] rcv_cycle = '0;

  function automatic void device_reset();
    rate_q   = TickPeriodReset;
    id_q     = DeviceIdReset;
    irq_mode = 1'b0;
    tick_cnt = '0;
    wr_ptr   = '0;
    rd_ptr   = '0;
    foreach (ring[i]) ring[i] = '0;
  endfunction

  // advances the device state by one word and returns what it must give back
  function automatic tty_result_t device_step(input bus_word_t w);
    tty_result_t r;
    logic        ring_ready;
    ptr_t        wr_next;
    logic [7:0]  rx_char;
    logic        got_char;
    r          = NoResult;
    ring_ready = (wr_ptr != rd_ptr);
    got_char   = 1'b0;
    rx_char    = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (irq_mode) begin
          if (tick_cnt == rate_q) begin
            tick_cnt = '0;
            if (w.rx_valid) begin
              ring[wr_ptr] = w.rx_byte;
              wr_ptr  = wr_ptr + 1'b1;
              wr_next = wr_ptr + 1'b1;
              // ring full: oldest byte is lost
              if (wr_next == rd_ptr) begin
                rd_ptr = rd_ptr + 1'b1;
                n_drops++;
              end
              r.rx_taken = 1'b1;
              r.irq      = 1'b1;
              n_samples++;
            end
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
      end
      CMD_READ: begin
        case (w.port)
          PORT_DATA: r.rdata = IdWordBase | {24'd0, id_q};
          PORT_RX: begin
            if (!irq_mode) begin
              if (w.rx_valid) begin
                got_char   = 1'b1;
                rx_char    = w.rx_byte;
                r.rx_taken = 1'b1;
              end
            end else if (ring_ready) begin
              got_char = 1'b1;
              rx_char  = ring[rd_ptr];
              rd_ptr   = rd_ptr + 1'b1;
            end
            if (got_char) r.rdata = {{24{rx_char[7]}}, rx_char};
          end
          PORT_STATUS: r.rdata = {31'd0, irq_mode ? ring_ready : w.rx_valid};
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (w.port)
          PORT_DATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = w.wdata[7:0];
          end
          PORT_RX: begin
            if (w.wdata == '0) begin
              irq_mode = 1'b0;
            end else begin
              irq_mode = 1'b1;
              tick_cnt = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // mode value: zero now and then, otherwise any nonzero word
  function automatic logic [31:0] mode_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) v = '0;
    else if (v == '0) v = 32'h1;
    return v;
  endfunction

  // mostly ticks and port one reads so the ring fills and drains
  function automatic bus_word_t rand_word();
    bus_word_t w;
    int pick;
    w.cmd      = CMD_TICK;
    w.port     = 2'($urandom_range(0, 3));
    w.wdata    = $urandom;
    w.rx_valid = ($urandom_range(0, 4) != 0);
    w.rx_byte  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      w.cmd = CMD_TICK;
    end else if (pick < 72) begin
      w.cmd  = CMD_READ;
      w.port = PORT_RX;
    end else if (pick < 80) begin
      w.cmd  = CMD_READ;
      w.port = PORT_STATUS;
    end else if (pick < 85) begin
      w.cmd = CMD_READ;
    end else if (pick < 92) begin
      w.cmd  = CMD_WRITE;
      w.port = PORT_DATA;
    end else if (pick < 95) begin
      w.cmd   = CMD_WRITE;
      w.port  = PORT_RX;
      w.wdata = mode_value();
    end else if (pick < 98) begin
      w.cmd  = CMD_WRITE;
      w.port = 2'($urandom_range(2, 3));
    end else begin
      w.cmd = CmdSpare;
    end
    return w;
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_word(input bus_word_t w, input logic typed, input tty_result_t known);
    int          gap;
    tty_result_t due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, w.rx_byte, w.rx_valid, w.wdata};
    s_axis_tuser  <= {w.port, w.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    due = device_step(w);
    if (typed) due = known;
    owed_results.push_back(due);
    n_sent++;
  endtask

  // stop sending and wait until every owed result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write; write enable stays up across back-to-back writes
  task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_TICK_PERIOD: rate_q = val;
      CFG_DEVICE_ID:   id_q   = val[7:0];
      default: ;  // no such register
    endcase
  endtask

  task automatic run_phase(input logic do_cfg, input logic [9:0] rate, input logic [9:0] id,
                           input logic spare, input logic start_mode, input int lead,
                           input int n_words);
    bus_word_t w;
    if (do_cfg) begin
      settle();
      cfg_write(CFG_TICK_PERIOD, rate);
      cfg_write(CFG_DEVICE_ID, id);
      if (spare) begin
        cfg_write(CfgSpareA, 10'($urandom));
        cfg_write(CfgSpareB, 10'($urandom));
      end
      cfg_we_i <= 1'b0;
    end
    // enter interrupt mode with a one-hot mode word
    if (start_mode) begin
      w = '{CMD_WRITE, PORT_RX, 32'h1 << $urandom_range(0, 31), 1'b0, 8'h00};
      send_word(w, 1'b0, NoResult);
    end
    // run of ticks with host data waiting, long enough to reach the sample point
    repeat (lead) begin
      w = '{CMD_TICK, 2'($urandom_range(0, 3)), $urandom, 1'b1, 8'($urandom_range(0, 255))};
      send_word(w, 1'b0, NoResult);
    end
    repeat (n_words) send_word(rand_word(), 1'b0, NoResult);
  endtask

  task automatic check_result(input logic [47:0] d);
    tty_result_t got;
    tty_result_t want;
    got = '{d[31:0], d[32], d[40:33], d[41], d[42]};
    if (owed_results.size() == 0) begin
      $error("result word %h arrived with nothing owed", d);
      n_errors++;
    end else begin
      want = owed_results.pop_front();
      n_checked++;
      if (got.tx_valid === 1'b1) n_tx++;
      if (got.rdata !== want.rdata) begin
        $error("rdata: expected %h, got %h", want.rdata, got.rdata);
        n_errors++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
        n_errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
        n_errors++;
      end
      if (got.rx_taken !== want.rx_taken) begin
        $error("rx_taken: expected %b, got %b", want.rx_taken, got.rx_taken);
        n_errors++;
      end
      if (got.irq !== want.irq) begin
        $error("irq: expected %b, got %b", want.irq, got.irq);
        n_errors++;
      end
    end
  endtask

  // receiver: ready pattern chosen by bits 8:7 of the cycle counter
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    rcv_cycle <= rcv_cycle + 1'b1;
    case (rcv_cycle[8:7])
      2'd0: m_axis_tready <= 1'b1;                          // no stalls
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);   // scattered stalls
      2'd2: m_axis_tready <= (rcv_cycle % 3 == 0);          // ready when the cycle counter is a multiple of three
      default: m_axis_tready <= rcv_cycle[3];               // follows bit 3 of the cycle counter
    endcase
  end

  // watchdog: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("timeout: %0d cycles with no word moving, %0d results owed",
             idle_cycles, owed_results.size());
    $display("FAIL tty_receive_fifo_device");
    $finish;
  end

  initial begin
    device_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset configuration
    for (int i = 0; i < NumProbes; i++) begin
      send_word(ProbeRows[i].w, ProbeRows[i].typed, ProbeRows[i].res);
    end

    // reset sample point of 50 reached by a long run of ticks
    run_phase(1'b0, 10'd0, 10'd0, 1'b0, 1'b1, 60, 110);
    // sample on every tick, id byte written with bits above the register
    run_phase(1'b1, 10'd0, 10'h3FF, 1'b0, 1'b1, 0, 130);
    // slowest setting, never reached in this run
    run_phase(1'b1, 10'd1023, 10'd0, 1'b0, 1'b1, 0, 60);
    // short period, spare indexes ignored
    run_phase(1'b1, 10'd1, 10'h25A, 1'b1, 1'b1, 0, 100);
    run_phase(1'b1, 10'd3, 10'($urandom), 1'b0, 1'b1, 0, 100);
    run_phase(1'b1, 10'($urandom_range(0, 15)), 10'($urandom), 1'b1, 1'b1, 0, 100);
    run_phase(1'b1, 10'd2, 10'($urandom), 1'b0, 1'b1, 0, 60);

    settle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d words, checked %0d results, %0d characters out", n_sent, n_checked, n_tx);
    $display("host bytes buffered %0d times, %0d oldest entries dropped on full ring",
             n_samples, n_drops);
    if (n_errors == 0) begin
      $display("PASS tty_receive_fifo_device");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL tty_receive_fifo_device");
    end
    $finish;
  end

endmodule
